// ----- rtl/tes_pkg.sv -----
`timescale 1ns / 1ps
// Package for the trace element sort and trim block.
// Holds field widths, defaults and the beat structs; no dependencies.
package tes_pkg;

    localparam int IDENT_W         = 6;
    localparam int BYTES_W         = 32;
    localparam int KEPT_TOTAL_W    = 40;
    localparam int THR_W           = 7;
    localparam int PCT_SCALE       = 100;
    localparam int MAX_IDENTS_DEF  = 64;
    localparam int TOTAL_WIDTH_DEF = 40;

    typedef enum logic [0:0] {
        REQ_SAMPLE = 1'b0,
        REQ_RUN    = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [0:0]         req_type;
        logic [IDENT_W-1:0] ident_index;
        logic [BYTES_W-1:0] sample_bytes;
    } in_beat_t;

    typedef struct packed {
        logic [IDENT_W-1:0]      kept_ident;
        logic [KEPT_TOTAL_W-1:0] kept_total;
        logic [IDENT_W-1:0]      rank;
        logic                    is_last;
        logic                    none_kept;
    } out_beat_t;

endpackage

// ----- rtl/tes_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/trace_element_sort_trim.sv -----
`timescale 1ns / 1ps
// Trace element sort and trim, top level. Uses tes_pkg and tes_ram.
// Sample beats are accepted back to back while idle; each read-modify-write of the totals RAM finishes
// in the following cycle, with forwarding for back-to-back samples to one identifier.
// A run beat gathers the present totals, sorts them by selection sort through the single read port
// of the sort RAM, then trims and emits the kept entries; output stalls hold it.
// Reset (rst_n, async low) clears present bits, count, threshold and handshakes.
module trace_element_sort_trim #(
    parameter int MAX_IDENTS  = tes_pkg::MAX_IDENTS_DEF,
    parameter int TOTAL_WIDTH = tes_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [tes_pkg::THR_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tes_pkg::in_beat_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tes_pkg::out_beat_t         out_data
);
    import tes_pkg::*;

    localparam int IW  = $clog2(MAX_IDENTS);
    localparam int CW  = $clog2(MAX_IDENTS + 1);
    localparam int GW  = TOTAL_WIDTH + CW;
    localparam int PW  = GW + THR_W;
    localparam int SEW = IDENT_W + TOTAL_WIDTH;
    localparam int WW  = (TOTAL_WIDTH > KEPT_TOTAL_W) ? TOTAL_WIDTH : KEPT_TOTAL_W;

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_GATHER   = 14'b00000000000010,
        ST_SORT_RD  = 14'b00000000000100,
        ST_SORT_1ST = 14'b00000000001000,
        ST_SORT_SCN = 14'b00000000010000,
        ST_SWAP1    = 14'b00000000100000,
        ST_SWAP2    = 14'b00000001000000,
        ST_THR_MUL  = 14'b00000010000000,
        ST_THR_RD   = 14'b00000100000000,
        ST_THR_ACC  = 14'b00001000000000,
        ST_THR_CMP  = 14'b00010000000000,
        ST_EMIT_RD  = 14'b00100000000000,
        ST_EMIT_LD  = 14'b01000000000000,
        ST_NONE     = 14'b10000000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [THR_W-1:0]        thr_reg;
    logic [MAX_IDENTS-1:0]   pres_reg, pres_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CW-1:0]           g_reg, g_next, start_reg, start_next;
    logic [IW-1:0]           sa_reg, sa_next, m_reg, m_next;
    logic [SEW-1:0]          ent_i_reg, ent_i_next, min_reg, min_next;
    logic [GW-1:0]           grand_reg, grand_next, cum_reg, cum_next;
    logic [PW-1:0]           thr_side_reg, thr_side_next;
    logic                    gv_reg, gv_next;
    logic [IDENT_W-1:0]      gid_reg, gid_next;
    logic                    p1_valid_reg;
    logic [IW-1:0]           p1_idx_reg;
    logic [BYTES_W-1:0]      p1_bytes_reg;
    logic                    fwd_valid_reg;
    logic [IW-1:0]           fwd_idx_reg;
    logic [TOTAL_WIDTH-1:0]  fwd_val_reg;
    logic                    out_valid_reg, out_valid_next;
    out_beat_t               out_reg, out_next;

    // totals RAM
    logic                    t_we;
    logic [IW-1:0]           t_raddr;
    logic [TOTAL_WIDTH-1:0]  t_rdata, t_wdata;
    // sort RAM: {ident, total}
    logic                    s_we;
    logic [IW-1:0]           s_waddr, s_raddr;
    logic [SEW-1:0]          s_wdata, s_rdata;

    logic                    in_acc, samp_ok, out_free;
    logic [TOTAL_WIDTH-1:0]  cur_tot;
    logic [TOTAL_WIDTH:0]    sum_tot;
    logic [GW-1:0]           cum_add;
    logic [PW-1:0]           pct_side;
    logic [WW-1:0]           tot_wide;

    tes_ram #(.WIDTH(TOTAL_WIDTH), .DEPTH(MAX_IDENTS)) u_tot_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (p1_idx_reg),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    tes_ram #(.WIDTH(SEW), .DEPTH(MAX_IDENTS)) u_sort_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign samp_ok   = (32'(in_data.ident_index) < MAX_IDENTS);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // sample read-modify-write, forward the write from the previous edge
    always_comb
    begin
        if (!pres_reg[p1_idx_reg])
        begin
            cur_tot = '0;
        end
        else if (fwd_valid_reg && fwd_idx_reg == p1_idx_reg)
        begin
            cur_tot = fwd_val_reg;
        end
        else
        begin
            cur_tot = t_rdata;
        end
        sum_tot = {1'b0, cur_tot} + (TOTAL_WIDTH + 1)'(p1_bytes_reg);
        t_wdata = sum_tot[TOTAL_WIDTH] ? '1 : sum_tot[TOTAL_WIDTH-1:0];
        t_we    = p1_valid_reg;
    end

    assign cum_add  = cum_reg + GW'(s_rdata[TOTAL_WIDTH-1:0]);
    assign pct_side = PW'(PCT_SCALE) * PW'(cum_reg);
    assign tot_wide = WW'(s_rdata[TOTAL_WIDTH-1:0]);

    always_comb
    begin
        state_next    = state_reg;
        pres_next     = pres_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        g_next        = g_reg;
        start_next    = start_reg;
        sa_next       = sa_reg;
        m_next        = m_reg;
        ent_i_next    = ent_i_reg;
        min_next      = min_reg;
        grand_next    = grand_reg;
        cum_next      = cum_reg;
        thr_side_next = thr_side_reg;
        gv_next       = 1'b0;
        gid_next      = gid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next      = out_reg;
        t_raddr       = in_data.ident_index[IW-1:0];
        s_we          = 1'b0;
        s_waddr       = n_reg[IW-1:0];
        s_wdata       = {gid_reg, t_rdata};
        s_raddr       = k_reg[IW-1:0];

        if (p1_valid_reg)
        begin
            pres_next[p1_idx_reg] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_data.req_type == REQ_RUN)
                begin
                    g_next     = '0;
                    n_next     = '0;
                    grand_next = '0;
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER:
            begin
                if (g_reg < CW'(MAX_IDENTS))
                begin
                    t_raddr  = g_reg[IW-1:0];
                    gv_next  = pres_reg[g_reg[IW-1:0]];
                    gid_next = IDENT_W'(g_reg);
                    g_next   = g_reg + 1'b1;
                end
                if (gv_reg)
                begin
                    s_we       = 1'b1;
                    n_next     = n_reg + 1'b1;
                    grand_next = grand_reg + GW'(t_rdata);
                end
                else if (g_reg == CW'(MAX_IDENTS))
                begin
                    i_next     = '0;
                    state_next = (n_reg > CW'(1)) ? ST_SORT_RD : ST_THR_MUL;
                end
            end
            ST_SORT_RD:
            begin
                s_raddr    = i_reg[IW-1:0];
                j_next     = i_reg + 1'b1;
                state_next = ST_SORT_1ST;
            end
            ST_SORT_1ST:
            begin
                ent_i_next = s_rdata;
                min_next   = s_rdata;
                m_next     = i_reg[IW-1:0];
                s_raddr    = j_reg[IW-1:0];
                sa_next    = j_reg[IW-1:0];
                j_next     = j_reg + 1'b1;
                state_next = ST_SORT_SCN;
            end
            ST_SORT_SCN:
            begin
                // first strictly smaller total wins
                if (s_rdata[TOTAL_WIDTH-1:0] < min_reg[TOTAL_WIDTH-1:0])
                begin
                    min_next = s_rdata;
                    m_next   = sa_reg;
                end
                if (j_reg < n_reg)
                begin
                    s_raddr = j_reg[IW-1:0];
                    sa_next = j_reg[IW-1:0];
                    j_next  = j_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_SWAP1;
                end
            end
            ST_SWAP1:
            begin
                s_we       = 1'b1;
                s_waddr    = i_reg[IW-1:0];
                s_wdata    = min_reg;
                state_next = ST_SWAP2;
            end
            ST_SWAP2:
            begin
                s_we       = 1'b1;
                s_waddr    = m_reg;
                s_wdata    = ent_i_reg;
                i_next     = i_reg + 1'b1;
                state_next = ((i_reg + CW'(2)) < n_reg) ? ST_SORT_RD : ST_THR_MUL;
            end
            ST_THR_MUL:
            begin
                thr_side_next = PW'(thr_reg) * PW'(grand_reg);
                k_next        = '0;
                cum_next      = '0;
                state_next    = (n_reg == '0) ? ST_NONE : ST_THR_RD;
            end
            ST_THR_RD:
            begin
                state_next = ST_THR_ACC;
            end
            ST_THR_ACC:
            begin
                cum_next   = cum_add;
                state_next = ST_THR_CMP;
            end
            ST_THR_CMP:
            begin
                if (pct_side >= thr_side_reg)
                begin
                    start_next = k_reg;
                    state_next = ST_EMIT_RD;
                end
                else if ((k_reg + 1'b1) == n_reg)
                begin
                    state_next = ST_NONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_THR_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.kept_ident = s_rdata[SEW-1 -: IDENT_W];
                    out_next.kept_total = tot_wide[KEPT_TOTAL_W-1:0];
                    out_next.rank       = IDENT_W'(k_reg - start_reg);
                    out_next.is_last    = ((k_reg + 1'b1) == n_reg);
                    out_next.none_kept  = 1'b0;
                    if ((k_reg + 1'b1) == n_reg)
                    begin
                        pres_next  = '0;
                        n_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_NONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next           = '0;
                    out_next.none_kept = 1'b1;
                    pres_next          = '0;
                    n_next             = '0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= '0;
            pres_reg      <= '0;
            n_reg         <= '0;
            gv_reg        <= 1'b0;
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pres_reg      <= pres_next;
            n_reg         <= n_next;
            gv_reg        <= gv_next;
            p1_valid_reg  <= in_acc && (in_data.req_type == REQ_SAMPLE) && samp_ok;
            fwd_valid_reg <= p1_valid_reg;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        g_reg        <= g_next;
        start_reg    <= start_next;
        sa_reg       <= sa_next;
        m_reg        <= m_next;
        ent_i_reg    <= ent_i_next;
        min_reg      <= min_next;
        grand_reg    <= grand_next;
        cum_reg      <= cum_next;
        thr_side_reg <= thr_side_next;
        gid_reg      <= gid_next;
        out_reg      <= out_next;
        p1_idx_reg   <= in_data.ident_index[IW-1:0];
        p1_bytes_reg <= in_data.sample_bytes;
        fwd_idx_reg  <= p1_idx_reg;
        fwd_val_reg  <= t_wdata;
    end

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWAP2 |-> $past(state_reg) == ST_SWAP1)
        else $error("swap second write without first");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(MAX_IDENTS))
        else $error("identifier count out of range");

    a_no_late_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_GATHER) |-> !p1_valid_reg)
        else $error("sample write overlaps a run");

    a_none_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.none_kept) |-> (!out_reg.is_last && out_reg.kept_total == '0))
        else $error("empty-run beat carries data");

endmodule

// ----- dv/tb_trace_element_sort_trim.sv -----
`timescale 1ns / 1ps
// Testbench for trace_element_sort_trim: directed table, then random sample/run sequences.
// Depends on tes_pkg and the RTL top; checks every output beat against the directed table or an in-bench predictor.
module tb_trace_element_sort_trim;
    import tes_pkg::*;

    localparam int NIDENT    = 64;
    localparam int CYCLE_CAP = 1000000;
    localparam logic [KEPT_TOTAL_W-1:0] TOTAL_SAT = {KEPT_TOTAL_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [THR_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_beat_t out_data;

    trace_element_sort_trim uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [KEPT_TOTAL_W-1:0] acc_total [NIDENT];
    bit                      acc_seen  [NIDENT];
    logic [THR_W-1:0]        thr_pct;
    out_beat_t               kept_q[$];

    int errs = 0;
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int items = 0;
    int seq_cnt = 0;

    typedef struct {
        in_beat_t  b;
        bit        typed;
        out_beat_t e;
    } row_t;

    function automatic out_beat_t mk_out(logic [5:0] id, logic [39:0] tot, logic [5:0] rk,
                                         logic last, logic none);
        out_beat_t o;
        o.kept_ident = id; o.kept_total = tot; o.rank = rk; o.is_last = last;
        o.none_kept = none;
        return o;
    endfunction

    function automatic in_beat_t mk_in(req_type_t rq, int id, logic [31:0] by);
        in_beat_t b;
        b.req_type = rq; b.ident_index = id[5:0]; b.sample_bytes = by;
        return b;
    endfunction

    // Sort present identifiers by total, trim the small tail, clear the store.
    task automatic trim_predict(bit keep);
        logic [5:0]  ord [NIDENT];
        logic [39:0] tot [NIDENT];
        logic [39:0] tv;
        logic [5:0]  ov;
        logic [63:0] grand, cum, thr_side;
        int n, m, start;
        n = 0;
        grand = 0;
        cum = 0;
        for (int i = 0; i < NIDENT; i++)
            if (acc_seen[i])
            begin
                ord[n] = i[5:0]; tot[n] = acc_total[i]; n++;
            end
        for (int i = 0; i + 1 < n; i++)
        begin
            m = i;
            for (int j = i + 1; j < n; j++)
                if (tot[j] < tot[m]) m = j;
            tv = tot[m]; tot[m] = tot[i]; tot[i] = tv;
            ov = ord[m]; ord[m] = ord[i]; ord[i] = ov;
        end
        for (int i = 0; i < n; i++) grand += tot[i];
        thr_side = grand * thr_pct;
        start = n;
        for (int i = 0; i < n; i++)
        begin
            cum += tot[i];
            if (cum * PCT_SCALE >= thr_side)
            begin
                start = i;
                break;
            end
        end
        if (keep)
        begin
            if (start >= n)
                kept_q.push_back(mk_out(6'd0, 40'd0, 6'd0, 1'b0, 1'b1));
            else
                for (int k = start; k < n; k++)
                    kept_q.push_back(mk_out(ord[k], tot[k], 6'(k - start),
                                            (k + 1 == n), 1'b0));
        end
        for (int i = 0; i < NIDENT; i++)
        begin
            acc_total[i] = '0; acc_seen[i] = 0;
        end
    endtask

    task automatic accumulate(in_beat_t b, bit keep);
        logic [40:0] sum;
        if (b.req_type == REQ_RUN)
            trim_predict(keep);
        else
        begin
            sum = acc_total[b.ident_index] + b.sample_bytes;
            acc_total[b.ident_index] = sum[40] ? TOTAL_SAT : sum[39:0];
            acc_seen[b.ident_index] = 1;
        end
    endtask

    // Drive one beat; valid stays high straight into the next beat when no gap is drawn.
    task automatic send_beat(in_beat_t b);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items++;
    endtask

    task automatic push_beat(in_beat_t b);
        send_beat(b);
        accumulate(b, 1);
    endtask

    task automatic drain();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (kept_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_threshold(logic [THR_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        thr_pct = v;
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("trace_element_sort_trim verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_beat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (kept_q.size() == 0)
            begin
                $error("unexpected beat %p", out_data);
                errs++;
            end
            else
            begin
                e = kept_q.pop_front();
                if (out_data.kept_ident !== e.kept_ident)
                begin
                    $error("kept_ident exp %0d got %0d", e.kept_ident, out_data.kept_ident);
                    errs++;
                end
                if (out_data.kept_total !== e.kept_total)
                begin
                    $error("kept_total exp %0h got %0h", e.kept_total, out_data.kept_total);
                    errs++;
                end
                if (out_data.rank !== e.rank)
                begin
                    $error("rank exp %0d got %0d", e.rank, out_data.rank);
                    errs++;
                end
                if (out_data.is_last !== e.is_last)
                begin
                    $error("is_last exp %0d got %0d", e.is_last, out_data.is_last);
                    errs++;
                end
                if (out_data.none_kept !== e.none_kept)
                begin
                    $error("none_kept exp %0d got %0d", e.none_kept, out_data.none_kept);
                    errs++;
                end
            end
        end
    end

    // One random sequence: samples into none, a few or all identifiers, then a run.
    task automatic random_seq();
        int n, id, reps, mode;
        logic [31:0] by;
        mode = $urandom_range(9);
        if (mode == 0)
            n = 0;
        else if (mode == 1)
            n = NIDENT;
        else
            n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++)
        begin
            id = (n == NIDENT) ? i : $urandom_range(NIDENT - 1);
            reps = (n == NIDENT) ? 1 : $urandom_range(1, 3);
            for (int r = 0; r < reps; r++)
            begin
                case ($urandom_range(3))
                    0: by = $urandom;
                    1: by = $urandom_range(20);
                    2: by = (mode == 2) ? 32'd7 : 32'hFFFF_FFFF;
                    default: by = $urandom_range(1000);
                endcase
                // noise: a stray run mid-sequence now and then
                if ($urandom_range(29) == 0)
                    push_beat(mk_in(REQ_RUN, $urandom, $urandom));
                push_beat(mk_in(REQ_SAMPLE, id, by));
            end
        end
        push_beat(mk_in(REQ_RUN, $urandom, $urandom));
    endtask

    initial
    begin
        row_t tbl[$];
        row_t rw;
        for (int i = 0; i < NIDENT; i++)
        begin
            acc_total[i] = '0; acc_seen[i] = 0;
        end
        thr_pct = '0;

        // run on an empty store
        tbl.push_back('{mk_in(REQ_RUN, 63, 32'hFFFF_FFFF), 1,
                        mk_out(6'd0, 40'd0, 6'd0, 1'b0, 1'b1)});
        tbl.push_back('{mk_in(REQ_SAMPLE, 63, 32'hFFFF_FFFF), 0, '0});
        tbl.push_back('{mk_in(REQ_RUN, 0, 0), 1,
                        mk_out(6'd63, 40'hFF_FFFF_FFFF >> 8, 6'd0, 1'b1, 1'b0)});
        // zero-byte sample still marks present
        tbl.push_back('{mk_in(REQ_SAMPLE, 0, 0), 0, '0});
        tbl.push_back('{mk_in(REQ_RUN, 0, 0), 1, mk_out(6'd0, 40'd0, 6'd0, 1'b1, 1'b0)});
        // zero grand total, several identifiers
        tbl.push_back('{mk_in(REQ_SAMPLE, 9, 0), 0, '0});
        tbl.push_back('{mk_in(REQ_SAMPLE, 3, 0), 0, '0});
        tbl.push_back('{mk_in(REQ_SAMPLE, 42, 0), 0, '0});
        tbl.push_back('{mk_in(REQ_RUN, 0, 0), 0, '0});
        // ties and ordering
        tbl.push_back('{mk_in(REQ_SAMPLE, 5, 100), 0, '0});
        tbl.push_back('{mk_in(REQ_SAMPLE, 1, 100), 0, '0});
        tbl.push_back('{mk_in(REQ_SAMPLE, 2, 50), 0, '0});
        tbl.push_back('{mk_in(REQ_SAMPLE, 2, 50), 0, '0});
        tbl.push_back('{mk_in(REQ_SAMPLE, 60, 1), 0, '0});
        tbl.push_back('{mk_in(REQ_SAMPLE, 7, 32'h8000_0000), 0, '0});
        tbl.push_back('{mk_in(REQ_RUN, 21, 32'h5555_5555), 0, '0});
        tbl.push_back('{mk_in(REQ_SAMPLE, 21, 32'hAAAA_AAAA), 0, '0});
        tbl.push_back('{mk_in(REQ_SAMPLE, 42, 32'h5555_5555), 0, '0});
        tbl.push_back('{mk_in(REQ_RUN, 42, 32'hAAAA_AAAA), 0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tbl[i])
        begin
            rw = tbl[i];
            send_beat(rw.b);
            accumulate(rw.b, !rw.typed);
            if (rw.typed) kept_q.push_back(rw.e);
        end

        // four idle and stall phases share the random budget; each threshold write drains first
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            while (items < 20 + 40 * (ph + 1))
            begin
                case (seq_cnt % 5)
                    0: set_threshold(7'd100);
                    1: set_threshold(7'd127);
                    2: set_threshold(7'd0);
                    3: set_threshold(7'd50);
                    default: set_threshold(7'($urandom_range(127)));
                endcase
                seq_cnt++;
                random_seq();
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (errs == 0)
            $display("trace_element_sort_trim verification clean");
        else
            $display("trace_element_sort_trim verification failed");
        $finish;
    end
endmodule
